// File: hw/rtl/cmat_pkg.sv
package cmat_pkg;

  localparam int unsigned ChanW          = 4;
  localparam int unsigned PriceW         = 24;
  localparam int unsigned BandW          = 10;
  localparam int unsigned CfgIdxW        = 1;
  localparam int unsigned NumChannelsDef = 16;
  localparam int unsigned WindowDef      = 5;

  typedef enum logic [1:0] {
    TrendUp   = 2'd0,
    TrendDown = 2'd1,
    TrendFlat = 2'd2
  } trend_e;

  typedef enum logic [CfgIdxW-1:0] {
    CfgPriceBand = 1'b0,
    CfgAvgBand   = 1'b1
  } cfg_reg_e;

  typedef enum logic [2:0] {
    SIdle,
    SHist,
    SCalc,
    SMul,
    SAvg
  } back_state_e;

  typedef struct packed {
    logic [BandW-1:0] price_band;
    logic [BandW-1:0] avg_band;
  } cmat_cfg_t;

  typedef struct packed {
    logic [ChanW-1:0]         channel;
    logic signed [PriceW-1:0] price;
  } cmat_in_t;

  typedef struct packed {
    logic [ChanW-1:0]         channel_out;
    trend_e                   price_trend;
    logic signed [PriceW-1:0] average;
    trend_e                   average_trend;
  } cmat_out_t;

endpackage

// File: hw/rtl/cmat_fifo.sv
module cmat_fifo
  import cmat_pkg::*;
#(
  parameter int unsigned Width = 8,
  parameter int unsigned Depth = 2
) (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             push_i,
  input  logic [Width-1:0] data_i,
  output logic             full_o,
  input  logic             pop_i,
  output logic [Width-1:0] data_o,
  output logic             empty_o
);

  localparam int unsigned PtrW = (Depth > 1) ? $clog2(Depth) : 1;
  localparam int unsigned CntW = $clog2(Depth + 1);

  logic [Width-1:0] mem_q [Depth];
  logic [PtrW-1:0]  wr_ptr_q, rd_ptr_q;
  logic [CntW-1:0]  cnt_q;
  logic             do_push, do_pop;

  assign full_o  = (cnt_q == CntW'(Depth));
  assign empty_o = (cnt_q == '0);
  assign data_o  = mem_q[rd_ptr_q];
  assign do_push = push_i && !full_o;
  assign do_pop  = pop_i && !empty_o;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      cnt_q    <= '0;
    end else begin
      if (do_push) begin
        wr_ptr_q <= (wr_ptr_q == PtrW'(Depth - 1)) ? '0 : wr_ptr_q + 1'b1;
      end
      if (do_pop) begin
        rd_ptr_q <= (rd_ptr_q == PtrW'(Depth - 1)) ? '0 : rd_ptr_q + 1'b1;
      end
      if (do_push && !do_pop) begin
        cnt_q <= cnt_q + 1'b1;
      end else if (do_pop && !do_push) begin
        cnt_q <= cnt_q - 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (do_push) begin
      mem_q[wr_ptr_q] <= data_i;
    end
  end

  a_cnt_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cnt_q <= CntW'(Depth))
    else $error("queue count beyond depth");

  a_push_lands: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (do_push && !do_pop) |=> !empty_o)
    else $error("transfer into queue lost");

endmodule

// File: hw/rtl/cmat_front.sv
module cmat_front
  import cmat_pkg::*;
#(
  parameter int unsigned NUM_CHANNELS = NumChannelsDef,
  localparam int unsigned ChW = (NUM_CHANNELS > 1) ? $clog2(NUM_CHANNELS) : 1
) (
  input  logic           clk_i,
  input  logic           rst_ni,
  input  logic           push_i,
  input  cmat_in_t       in_data_i,
  output logic           full_o,
  input  logic           pop_i,
  output logic           empty_o,
  output logic [ChW-1:0] idx_o,
  output cmat_in_t       item_o
);

  localparam int unsigned MapN = 1 << ChanW;
  localparam int unsigned QW   = ChW + $bits(cmat_in_t);

  // channel number folded onto the channels that have state
  function automatic logic [MapN-1:0][7:0] chan_map_f(int unsigned n);
    logic [MapN-1:0][7:0] m;
    int unsigned v;
    for (int unsigned i = 0; i < MapN; i++) begin
      v = i;
      for (int unsigned k = 0; k < MapN; k++) begin
        if (v >= n) begin
          v = v - n;
        end
      end
      m[i] = v[7:0];
    end
    return m;
  endfunction

  localparam logic [MapN-1:0][7:0] ChanMap = chan_map_f(NUM_CHANNELS);

  logic [ChW-1:0] idx;
  logic [QW-1:0]  q_din, q_dout;

  assign idx   = ChanMap[in_data_i.channel][ChW-1:0];
  assign q_din = {idx, in_data_i};

  cmat_fifo #(
    .Width(QW),
    .Depth(2)
  ) u_cmd_q (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .push_i (push_i),
    .data_i (q_din),
    .full_o (full_o),
    .pop_i  (pop_i),
    .data_o (q_dout),
    .empty_o(empty_o)
  );

  assign idx_o  = q_dout[QW-1 -: ChW];
  assign item_o = cmat_in_t'(q_dout[$bits(cmat_in_t)-1:0]);

endmodule

// File: hw/rtl/cmat_back.sv
module cmat_back
  import cmat_pkg::*;
#(
  parameter int unsigned NUM_CHANNELS = NumChannelsDef,
  parameter int unsigned WINDOW       = WindowDef,
  localparam int unsigned ChW = (NUM_CHANNELS > 1) ? $clog2(NUM_CHANNELS) : 1
) (
  input  logic           clk_i,
  input  logic           rst_ni,
  input  cmat_cfg_t      cfg_i,
  input  logic           q_empty_i,
  output logic           q_pop_o,
  input  logic [ChW-1:0] q_idx_i,
  input  cmat_in_t       q_item_i,
  input  logic           out_full_i,
  output logic           out_push_o,
  output cmat_out_t      out_item_o
);

  localparam int unsigned FillW     = $clog2(WINDOW + 1);
  localparam int unsigned SlotW     = (WINDOW > 1) ? $clog2(WINDOW) : 1;
  localparam int unsigned SumW      = PriceW + $clog2(WINDOW);
  localparam int unsigned ShK       = SumW + $clog2(WINDOW);
  localparam int unsigned RecW      = ShK + 1;
  localparam int unsigned ProdW     = SumW + RecW;
  localparam int unsigned HistDepth = NUM_CHANNELS * WINDOW;
  localparam int unsigned HAddrW    = (HistDepth > 1) ? $clog2(HistDepth) : 1;

  function automatic trend_e trend_f(logic signed [PriceW:0] diff, logic [BandW-1:0] band);
    logic signed [PriceW:0] b;
    b = signed'({{(PriceW + 1 - BandW){1'b0}}, band});
    if (diff > b) begin
      return TrendUp;
    end
    if (-diff > b) begin
      return TrendDown;
    end
    return TrendFlat;
  endfunction

  // ceil(2^ShK / d): exact floor quotient for any sum magnitude below 2^SumW
  logic [RecW-1:0] recip_tab [WINDOW + 1];
  assign recip_tab[0] = '0;
  for (genvar d = 1; d <= WINDOW; d++) begin : g_recip
    localparam logic [63:0] RecipFull = ((64'd1 << ShK) + d - 1) / d;
    assign recip_tab[d] = RecipFull[RecW-1:0];
  end

  back_state_e state_q, state_d;

  // per-channel state, valid bit stands in for the zero reset value
  logic [NUM_CHANNELS-1:0]  vld_q;
  logic [FillW-1:0]         fill_mem [NUM_CHANNELS];
  logic [SlotW-1:0]         slot_mem [NUM_CHANNELS];
  logic signed [SumW-1:0]   sum_mem  [NUM_CHANNELS];
  logic signed [PriceW-1:0] lavg_mem [NUM_CHANNELS];
  logic signed [PriceW-1:0] hist_mem [HistDepth];

  logic                     rd_vld_q;
  logic [FillW-1:0]         rd_fill_q;
  logic [SlotW-1:0]         rd_slot_q;
  logic signed [SumW-1:0]   rd_sum_q;
  logic signed [PriceW-1:0] rd_lavg_q;

  logic [ChW-1:0]           ch_q;
  cmat_in_t                 item_q;
  logic [FillW-1:0]         fill_q;
  logic [SlotW-1:0]         slot_q;
  logic signed [SumW-1:0]   sum_q;
  logic signed [PriceW-1:0] lavg_q;
  logic signed [PriceW-1:0] hist_a_q, hist_b_q;
  trend_e                   ptrend_q;
  logic                     neg_q;
  logic [ProdW-1:0]         prod_q;

  logic [FillW-1:0]         fill_eff;
  logic [SlotW-1:0]         slot_sel;
  logic signed [SumW-1:0]   sum_eff, sum_nxt, old_ext;
  logic signed [PriceW-1:0] lavg_eff;
  logic [HAddrW-1:0]        hbase, addr_a, addr_b, addr_w;
  logic                     win_full;
  trend_e                   ptrend_d, atrend;
  logic [SumW-1:0]          mag;
  logic [PriceW-1:0]        quo;
  logic signed [PriceW-1:0] avg;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= SIdle;
    end else begin
      state_q <= state_d;
    end
  end

  always_comb begin
    state_d    = state_q;
    q_pop_o    = 1'b0;
    out_push_o = 1'b0;
    unique case (state_q)
      SIdle: begin
        if (!q_empty_i && !out_full_i) begin
          q_pop_o = 1'b1;
          state_d = SHist;
        end
      end
      SHist: state_d = SCalc;
      SCalc: state_d = SMul;
      SMul:  state_d = SAvg;
      SAvg: begin
        out_push_o = 1'b1;
        state_d    = SIdle;
      end
      default: state_d = SIdle;
    endcase
  end

  // state read results, masked for channels never written
  assign fill_eff = rd_vld_q ? rd_fill_q : '0;
  assign sum_eff  = rd_vld_q ? rd_sum_q  : '0;
  assign lavg_eff = rd_vld_q ? rd_lavg_q : '0;
  assign slot_sel = (fill_eff == '0) ? '0 :
                    (rd_slot_q == SlotW'(WINDOW - 1)) ? '0 : rd_slot_q + 1'b1;

  assign hbase  = HAddrW'(ch_q) * HAddrW'(WINDOW);
  assign addr_a = hbase + HAddrW'(rd_slot_q);
  assign addr_b = hbase + HAddrW'(slot_sel);
  assign addr_w = hbase + HAddrW'(slot_q);

  assign win_full = (fill_q == FillW'(WINDOW));
  assign old_ext  = win_full ? SumW'(hist_b_q) : '0;
  assign sum_nxt  = sum_q + SumW'(item_q.price) - old_ext;
  assign ptrend_d = (fill_q == '0) ? TrendUp :
                    trend_f({item_q.price[PriceW-1], item_q.price} -
                            {hist_a_q[PriceW-1], hist_a_q}, cfg_i.price_band);

  assign mag = sum_q[SumW-1] ? SumW'(-sum_q) : SumW'(sum_q);
  assign quo = prod_q[ShK +: PriceW];
  assign avg = neg_q ? -signed'(quo) : signed'(quo);
  assign atrend = (lavg_q <= 0) ? TrendUp :
                  trend_f({avg[PriceW-1], avg} - {lavg_q[PriceW-1], lavg_q},
                          cfg_i.avg_band);

  assign out_item_o = '{
    channel_out:   item_q.channel,
    price_trend:   ptrend_q,
    average:       avg,
    average_trend: atrend
  };

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_q <= '0;
    end else if (out_push_o) begin
      vld_q[ch_q] <= 1'b1;
    end
  end

  always_ff @(posedge clk_i) begin
    if (q_pop_o) begin
      ch_q      <= q_idx_i;
      item_q    <= q_item_i;
      rd_vld_q  <= vld_q[q_idx_i];
      rd_fill_q <= fill_mem[q_idx_i];
      rd_slot_q <= slot_mem[q_idx_i];
      rd_sum_q  <= sum_mem[q_idx_i];
      rd_lavg_q <= lavg_mem[q_idx_i];
    end
    if (state_q == SHist) begin
      fill_q   <= fill_eff;
      slot_q   <= slot_sel;
      sum_q    <= sum_eff;
      lavg_q   <= lavg_eff;
      hist_a_q <= hist_mem[addr_a];
      hist_b_q <= hist_mem[addr_b];
    end
    if (state_q == SCalc) begin
      ptrend_q         <= ptrend_d;
      sum_q            <= sum_nxt;
      fill_q           <= win_full ? fill_q : fill_q + 1'b1;
      hist_mem[addr_w] <= item_q.price;
    end
    if (state_q == SMul) begin
      neg_q  <= sum_q[SumW-1];
      prod_q <= ProdW'(mag) * ProdW'(recip_tab[fill_q]);
    end
    if (out_push_o) begin
      fill_mem[ch_q] <= fill_q;
      slot_mem[ch_q] <= slot_q;
      sum_mem[ch_q]  <= sum_q;
      lavg_mem[ch_q] <= avg;
    end
  end

  a_result_follows: assert property (@(posedge clk_i) disable iff (!rst_ni)
    q_pop_o |-> ##4 out_push_o)
    else $error("result not produced four cycles after command pop");

  a_fill_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == SMul) |-> ((fill_q != '0) && (fill_q <= FillW'(WINDOW))))
    else $error("divisor out of range");

  a_room_out: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_push_o |-> !out_full_i)
    else $error("result pushed into full queue");

endmodule

// File: hw/rtl/channel_moving_average_trend_top.sv
// chan  dir  handshake          payload
// in    in   push / full        in_data_i  (cmat_in_t: channel, price)
// out   out  empty / pop        out_data_o (cmat_out_t: channel_out, trends, average)
// cfg   in   cfg_we_i           cfg_idx_i, cfg_data_i (0 price band, 1 average band)
//
// Each item passes through the back sequencer's steps in order: channel state read, history
// read, sum update, reciprocal multiply, write back. The sequencer takes no new item until
// the last one is written back, and it does not take one while the output queue is full.
// Two-entry queues on both sides let input transfers continue while results wait.
// Reset clears per-channel valid bits at once; there is no clearing pass.
module channel_moving_average_trend_top
  import cmat_pkg::*;
#(
  parameter int unsigned NUM_CHANNELS = NumChannelsDef,
  parameter int unsigned WINDOW       = WindowDef
) (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               push,
  output logic               full,
  input  cmat_in_t           in_data_i,
  output logic               empty,
  input  logic               pop,
  output cmat_out_t          out_data_o,
  input  logic               cfg_we_i,
  input  logic [CfgIdxW-1:0] cfg_idx_i,
  input  logic [BandW-1:0]   cfg_data_i
);

  localparam int unsigned ChW  = (NUM_CHANNELS > 1) ? $clog2(NUM_CHANNELS) : 1;
  localparam int unsigned OutW = $bits(cmat_out_t);

  cmat_cfg_t      cfg_q;
  logic           cq_pop, cq_empty;
  logic [ChW-1:0] cq_idx;
  cmat_in_t       cq_item;
  logic           oq_push, oq_full;
  cmat_out_t      oq_item;
  logic [OutW-1:0] oq_dout;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q <= '0;
    end else if (cfg_we_i) begin
      unique case (cfg_reg_e'(cfg_idx_i))
        CfgPriceBand: cfg_q.price_band <= cfg_data_i;
        CfgAvgBand:   cfg_q.avg_band   <= cfg_data_i;
        default: ;
      endcase
    end
  end

  cmat_front #(
    .NUM_CHANNELS(NUM_CHANNELS)
  ) u_front (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .push_i   (push),
    .in_data_i(in_data_i),
    .full_o   (full),
    .pop_i    (cq_pop),
    .empty_o  (cq_empty),
    .idx_o    (cq_idx),
    .item_o   (cq_item)
  );

  cmat_back #(
    .NUM_CHANNELS(NUM_CHANNELS),
    .WINDOW      (WINDOW)
  ) u_back (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .cfg_i     (cfg_q),
    .q_empty_i (cq_empty),
    .q_pop_o   (cq_pop),
    .q_idx_i   (cq_idx),
    .q_item_i  (cq_item),
    .out_full_i(oq_full),
    .out_push_o(oq_push),
    .out_item_o(oq_item)
  );

  cmat_fifo #(
    .Width(OutW),
    .Depth(2)
  ) u_out_q (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .push_i (oq_push),
    .data_i (oq_item),
    .full_o (oq_full),
    .pop_i  (pop),
    .data_o (oq_dout),
    .empty_o(empty)
  );

  assign out_data_o = cmat_out_t'(oq_dout);

endmodule
